/* rtl/core/bgc_pkg.sv */
`timescale 1ns / 1ps

package bgc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_EDGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MAX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_GAP    = 3'd5;

  localparam int MS_W  = 32;
  localparam int GAP_W = 14;
  localparam int EV_W  = 3;

  // Edge counts at which a gesture can be classified
  localparam int CNT_SINGLE = 2;
  localparam int CNT_DOUBLE = 4;
  localparam int CNT_TRIPLE = 6;

  // Number of stored times the classifier looks at
  localparam int CLS_TIMES = 6;

  typedef logic [MS_W-1:0] ms_t;
  typedef logic [CLS_TIMES-1:0][MS_W-1:0] cls_times_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE      = 3'd0,
    EV_NOT_READY = 3'd1,
    EV_SHORT     = 3'd2,
    EV_LONG      = 3'd3,
    EV_HOLD      = 3'd4,
    EV_DOUBLE    = 3'd5,
    EV_TRIPLE    = 3'd6,
    EV_INVALID   = 3'd7
  } event_t;

  typedef struct packed {
    logic              initial_edge;
    logic [15:0]       debounce_ms;
    logic [15:0]       short_max_ms;
    logic [15:0]       long_max_ms;
    logic [15:0]       hold_max_ms;
    logic [GAP_W-1:0]  multi_gap_ms;
  } cfg_t;

  typedef struct packed {
    event_t code;
    logic   clr;
  } cls_res_t;

endpackage

/* rtl/core/bgc_classify.sv */
`timescale 1ns / 1ps

module bgc_classify #(
  parameter int CNT_W = 3
) (
  input  logic [CNT_W-1:0]    cnt,
  input  bgc_pkg::cls_times_t times,
  input  bgc_pkg::ms_t        now_ms,
  input  bgc_pkg::cfg_t       cfg,
  output bgc_pkg::cls_res_t   res
);

  localparam int GW = bgc_pkg::GAP_W + 3;

  bgc_pkg::ms_t  since;
  logic [GW-1:0] gap1, gap2, gap3, gap4, gap5;
  logic          ok3, ok5;
  bgc_pkg::ms_t  d;

  assign since = now_ms - times[0];
  assign d     = times[1];

  // Window for the k-th edge offset is k gap units
  assign gap1 = GW'(cfg.multi_gap_ms);
  assign gap2 = GW'(cfg.multi_gap_ms) << 1;
  assign gap3 = GW'(cfg.multi_gap_ms) * GW'(3);
  assign gap4 = GW'(cfg.multi_gap_ms) << 2;
  assign gap5 = GW'(cfg.multi_gap_ms) * GW'(5);

  assign ok3 = (times[1] < bgc_pkg::MS_W'(gap1)) && (times[2] < bgc_pkg::MS_W'(gap2)) &&
               (times[3] < bgc_pkg::MS_W'(gap3));
  assign ok5 = ok3 && (times[4] < bgc_pkg::MS_W'(gap4)) &&
               (times[5] < bgc_pkg::MS_W'(gap5));

  always_comb begin
    res.code = bgc_pkg::EV_NONE;
    res.clr  = 1'b0;
    if (cnt == CNT_W'(bgc_pkg::CNT_SINGLE)) begin
      if (since <= bgc_pkg::MS_W'(cfg.short_max_ms)) begin
        res.code = bgc_pkg::EV_NOT_READY;
      end else begin
        res.clr = 1'b1;
        if (d < bgc_pkg::MS_W'(cfg.short_max_ms)) begin
          res.code = bgc_pkg::EV_SHORT;
        end else if (d < bgc_pkg::MS_W'(cfg.long_max_ms)) begin
          res.code = bgc_pkg::EV_LONG;
        end else if (d < bgc_pkg::MS_W'(cfg.hold_max_ms)) begin
          res.code = bgc_pkg::EV_HOLD;
        end else begin
          res.code = bgc_pkg::EV_INVALID;
        end
      end
    end else if (cnt == CNT_W'(bgc_pkg::CNT_DOUBLE)) begin
      if (since <= bgc_pkg::MS_W'(gap3)) begin
        res.code = bgc_pkg::EV_NOT_READY;
      end else begin
        res.clr  = 1'b1;
        res.code = ok3 ? bgc_pkg::EV_DOUBLE : bgc_pkg::EV_INVALID;
      end
    end else if (cnt == CNT_W'(bgc_pkg::CNT_TRIPLE)) begin
      res.clr  = 1'b1;
      res.code = ok5 ? bgc_pkg::EV_TRIPLE : bgc_pkg::EV_INVALID;
    end
  end

endmodule

/* rtl/core/button_gesture_classifier_core.sv */
`timescale 1ns / 1ps

// Push-button gesture classifier. Each input word is either a timestamped pin edge
// (in_mode 0) or a poll (in_mode 1); a poll always returns one word carrying the
// gesture code, an edge returns nothing. The block takes one word per cycle: a word
// is registered on entry, processed against the gesture state when it leaves the entry
// register, and a poll's result lands in the output register, held there until taken.
// Input stalls only in reset or when a poll in the entry register meets a full output
// register that is itself stalled. The user must write configuration only while idle;
// the block itself does not enforce it.
module button_gesture_classifier_core #(
  parameter int MAX_EDGES = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_mode,
  input  logic                             in_edge_rising,
  input  logic [31:0]                      in_now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_event_code,
  input  logic                             cfg_we,
  input  logic [bgc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bgc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_EDGES + 1);
  localparam int IDX_W = $clog2(MAX_EDGES);

  bgc_pkg::cfg_t       cfg_r;

  logic                stg_valid_r;
  logic                stg_mode_r;
  logic                stg_rising_r;
  bgc_pkg::ms_t        stg_now_r;
  logic                stg_go;
  logic                in_acc;

  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_code_r, out_code_nxt;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  bgc_pkg::ms_t        times_r [MAX_EDGES];
  bgc_pkg::ms_t        times_nxt [MAX_EDGES];
  logic                expect_r, expect_nxt;
  bgc_pkg::ms_t        lock_start_r, lock_start_nxt;
  logic                lock_act_r, lock_act_nxt;

  logic                edge_take;
  logic                seq_full;
  bgc_pkg::ms_t        lock_elapsed;
  bgc_pkg::cls_times_t cls_times;
  bgc_pkg::cls_res_t   cls_res;

  // Handshake
  assign stg_go   = stg_valid_r && !(stg_mode_r && out_valid_r && out_stall);
  assign in_stall = !rst_n || (stg_valid_r && !stg_go);
  assign in_acc   = in_valid && !in_stall;

  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_edge <= 1'b0;
      cfg_r.debounce_ms  <= 16'd50;
      cfg_r.short_max_ms <= 16'd400;
      cfg_r.long_max_ms  <= 16'd2000;
      cfg_r.hold_max_ms  <= 16'd10000;
      cfg_r.multi_gap_ms <= bgc_pkg::GAP_W'(400);
    end else if (cfg_we) begin
      case (cfg_index)
        bgc_pkg::REG_INITIAL_EDGE: cfg_r.initial_edge <= cfg_wdata[0];
        bgc_pkg::REG_DEBOUNCE:     cfg_r.debounce_ms  <= cfg_wdata;
        bgc_pkg::REG_SHORT_MAX:    cfg_r.short_max_ms <= cfg_wdata;
        bgc_pkg::REG_LONG_MAX:     cfg_r.long_max_ms  <= cfg_wdata;
        bgc_pkg::REG_HOLD_MAX:     cfg_r.hold_max_ms  <= cfg_wdata;
        bgc_pkg::REG_MULTI_GAP:    cfg_r.multi_gap_ms <= cfg_wdata[bgc_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_acc) begin
      stg_valid_r <= 1'b1;
    end else if (stg_go) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_mode_r   <= in_mode;
      stg_rising_r <= in_edge_rising;
      stg_now_r    <= in_now_ms;
    end
  end

  // Classifier sees the first six stored times
  always_comb begin
    for (int k = 0; k < bgc_pkg::CLS_TIMES; k++) begin
      cls_times[k] = times_r[k];
    end
  end

  bgc_classify #(
    .CNT_W (CNT_W)
  ) u_classify (
    .cnt    (cnt_r),
    .times  (cls_times),
    .now_ms (stg_now_r),
    .cfg    (cfg_r),
    .res    (cls_res)
  );

  assign lock_elapsed = stg_now_r - lock_start_r;
  assign seq_full     = (cnt_r >= CNT_W'(MAX_EDGES));
  assign edge_take    = stg_go && !stg_mode_r && (stg_rising_r == expect_r) &&
                        !(lock_act_r && (lock_elapsed < bgc_pkg::MS_W'(cfg_r.debounce_ms)));

  // Gesture state update
  always_comb begin
    cnt_nxt        = cnt_r;
    expect_nxt     = expect_r;
    lock_start_nxt = lock_start_r;
    lock_act_nxt   = lock_act_r;
    for (int i = 0; i < MAX_EDGES; i++) begin
      times_nxt[i] = times_r[i];
    end
    if (edge_take) begin
      expect_nxt     = !expect_r;
      lock_start_nxt = stg_now_r;
      lock_act_nxt   = 1'b1;
      if (seq_full) begin
        // A full sequence restarts with this word as its first edge.
        for (int i = 0; i < MAX_EDGES; i++) begin
          times_nxt[i] = '0;
        end
        times_nxt[0] = stg_now_r;
        cnt_nxt      = CNT_W'(1);
        expect_nxt   = !cfg_r.initial_edge;
      end else begin
        for (int i = 0; i < MAX_EDGES; i++) begin
          if (cnt_r[IDX_W-1:0] == IDX_W'(i)) begin
            times_nxt[i] = (i == 0) ? stg_now_r : (stg_now_r - times_r[0]);
          end
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else if (stg_go && stg_mode_r && cls_res.clr) begin
      cnt_nxt    = '0;
      expect_nxt = cfg_r.initial_edge;
      for (int i = 0; i < MAX_EDGES; i++) begin
        times_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      expect_r     <= 1'b0;
      lock_start_r <= '0;
      lock_act_r   <= 1'b0;
      for (int i = 0; i < MAX_EDGES; i++) begin
        times_r[i] <= '0;
      end
    end else begin
      cnt_r        <= cnt_nxt;
      expect_r     <= expect_nxt;
      lock_start_r <= lock_start_nxt;
      lock_act_r   <= lock_act_nxt;
      for (int i = 0; i < MAX_EDGES; i++) begin
        times_r[i] <= times_nxt[i];
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    if (stg_go && stg_mode_r) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = cls_res.code;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
  end

endmodule

/* rtl/core/bgc_checker.sv */
`timescale 1ns / 1ps

module bgc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_event_code
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // A held result word keeps its code.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_code))
    else $error("result word changed while stalled");

  // Input is only held back by a stalled, full output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A fresh result must come from an accepted poll.
  a_result_from_poll: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc && in_mode, 2))
    else $error("result word without a poll");

  // An edge word never produces a result.
  a_edge_silent: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_acc && !in_mode, 2) && !$past(out_valid) |-> !out_valid)
    else $error("edge word produced a result");

endmodule

bind button_gesture_classifier_core bgc_checker u_bgc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_event_code (out_event_code)
);
